>>> src/rfa_pkg.sv
package rfa_pkg;

	localparam int ACTION_W = 4;
	localparam int INDEX_W = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W = 64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_IN   = 4'd0,
		ACT_MOV  = 4'd1,
		ACT_ADD  = 4'd2,
		ACT_SUB  = 4'd3,
		ACT_MUL  = 4'd4,
		ACT_DIV  = 4'd5,
		ACT_OUT  = 4'd6,
		ACT_XCHG = 4'd7,
		ACT_MOD  = 4'd8,
		ACT_AND  = 4'd9,
		ACT_OR   = 4'd10,
		ACT_XOR  = 4'd11
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NONE = 2'd0,
		STAT_OUT  = 2'd1,
		STAT_DIV0 = 2'd2
	} status_t;

endpackage

>>> src/rfa_if.sv
interface rfa_in_if;
	logic                              valid;
	logic                              ready;
	logic [rfa_pkg::ACTION_W-1:0]      action;
	logic [rfa_pkg::INDEX_W-1:0]       dest_reg;
	logic [rfa_pkg::INDEX_W-1:0]       first_src;
	logic [rfa_pkg::INDEX_W-1:0]       second_src;
	logic                              three_form;
	logic signed [rfa_pkg::VALUE_W-1:0] immediate;

	modport source (output valid, action, dest_reg, first_src, second_src, three_form,
		immediate, input ready);
	modport sink (input valid, action, dest_reg, first_src, second_src, three_form,
		immediate, output ready);
endinterface

interface rfa_out_if;
	logic                               valid;
	logic                               ready;
	logic [rfa_pkg::STATUS_W-1:0]       status;
	logic signed [rfa_pkg::VALUE_W-1:0] out_value;

	modport source (output valid, status, out_value, input ready);
	modport sink (input valid, status, out_value, output ready);
endinterface

>>> src/register_file_alu_interpreter.sv
// Channel  | Direction | Payload                                              | Transfer
// ---------+-----------+------------------------------------------------------+----------------
// instr    | in        | action, dest_reg, first_src, second_src, three_form, | valid && ready
//          |           | immediate                                            |
// result   | out       | status, out_value                                    | valid && ready
//
// One instruction is in flight at a time; instr.ready is high only while the sequencer idles.
// IN, MOV, ADD, SUB, AND, OR, XOR, OUT, unused codes and a divide by zero go from dispatch to
// finish; XCHG adds a write step. MUL loops in S_MUL; DIV/MOD take magnitudes, loop in S_DIV.
// S_FIX writes back. The single shared adder retires one multiplier or quotient bit per cycle.
// Reset clears the register file at once through per-entry valid bits.
// The result register frees the sequencer: a new instruction is taken while a result waits,
// and only the final step of the next instruction stalls on an unread result.
module register_file_alu_interpreter #(
	parameter int NUM_REGS   = 4,
	parameter int DATA_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rfa_in_if.sink     instr,
	rfa_out_if.source  result
);

	localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int WIDE_W = IDX_W + rfa_pkg::INDEX_W;
	localparam int CNT_W  = $clog2(DATA_WIDTH);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_XCHG     = 9'b000000100,
		S_MUL      = 9'b000001000,
		S_ABSA     = 9'b000010000,
		S_ABSB     = 9'b000100000,
		S_DIV      = 9'b001000000,
		S_FIX      = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] regs_mem [NUM_REGS];
	logic [NUM_REGS-1:0]   valid_q;

	logic [rfa_pkg::ACTION_W-1:0] op_q;
	logic [rfa_pkg::INDEX_W-1:0]  dest_q;
	logic [rfa_pkg::INDEX_W-1:0]  src_q;
	logic [DATA_WIDTH-1:0]        imm_q;
	logic [DATA_WIDTH-1:0]        a_q;
	logic [DATA_WIDTH-1:0]        b_q;
	logic [DATA_WIDTH-1:0]        rem_q;
	logic                         neg_q;
	logic [CNT_W-1:0]             cnt_q;
	rfa_pkg::status_t             stat_q;
	logic                         out_valid_q;
	rfa_pkg::status_t             out_status_q;
	logic [rfa_pkg::VALUE_W-1:0]  out_value_q;

	logic                         accept;
	logic                         is_alu;
	logic [rfa_pkg::INDEX_W-1:0]  rd0_idx;
	logic [rfa_pkg::INDEX_W-1:0]  rd1_idx;
	logic [WIDE_W-1:0]            rd0_wide;
	logic [WIDE_W-1:0]            rd1_wide;
	logic [WIDE_W-1:0]            wr_wide;
	logic                         wr_req;
	logic                         wr_en;
	logic [rfa_pkg::INDEX_W-1:0]  wr_idx;
	logic [DATA_WIDTH-1:0]        wr_data;
	logic [DATA_WIDTH-1:0]        alu_x;
	logic [DATA_WIDTH-1:0]        alu_y;
	logic                         alu_sub;
	logic [DATA_WIDTH:0]          alu_sum;
	logic                         alu_carry;
	logic [DATA_WIDTH-1:0]        div_shift;
	logic [DATA_WIDTH-1:0]        fix_sel;
	logic                         last_step;
	logic                         out_free;

	assign accept    = instr.valid && instr.ready;
	assign last_step = cnt_q == CNT_W'(DATA_WIDTH - 1);
	assign out_free  = !out_valid_q || result.ready;

	// Three-operand ALU forms read first/second source; everything else reads dest/first.
	always_comb begin
		case (instr.action) inside
			rfa_pkg::ACT_ADD, rfa_pkg::ACT_SUB, rfa_pkg::ACT_MUL, rfa_pkg::ACT_DIV,
			rfa_pkg::ACT_MOD, rfa_pkg::ACT_AND, rfa_pkg::ACT_OR, rfa_pkg::ACT_XOR:
				is_alu = 1'b1;
			default:
				is_alu = 1'b0;
		endcase
	end

	assign rd0_idx  = (is_alu && instr.three_form) ? instr.first_src : instr.dest_reg;
	assign rd1_idx  = (is_alu && instr.three_form) ? instr.second_src : instr.first_src;
	assign rd0_wide = WIDE_W'(rd0_idx);
	assign rd1_wide = WIDE_W'(rd1_idx);
	assign wr_wide  = WIDE_W'(wr_idx);
	assign wr_en    = wr_req && (wr_wide < WIDE_W'(NUM_REGS));

	assign div_shift = {rem_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
	assign fix_sel   = (op_q == rfa_pkg::ACT_DIV) ? a_q : rem_q;

	// Shared adder: add, subtract, negate, multiply accumulate and trial subtract.
	always_comb begin
		alu_x   = a_q;
		alu_y   = b_q;
		alu_sub = 1'b0;
		unique case (state_q)
			S_DISPATCH: alu_sub = op_q == rfa_pkg::ACT_SUB;
			S_MUL: begin
				alu_x = rem_q;
			end
			S_ABSA: begin
				alu_x   = '0;
				alu_sub = 1'b1;
			end
			S_ABSB: begin
				alu_x   = '0;
				alu_y   = b_q;
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_x   = div_shift;
				alu_sub = 1'b1;
			end
			S_FIX: begin
				alu_x   = '0;
				alu_y   = fix_sel;
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_ABSA) begin
			alu_sum = {1'b0, alu_x} + {1'b0, ~a_q} + (DATA_WIDTH + 1)'(1);
		end else begin
			alu_sum = {1'b0, alu_x} + {1'b0, alu_y ^ {DATA_WIDTH{alu_sub}}}
				+ (DATA_WIDTH + 1)'(alu_sub);
		end
	end

	// A set carry on subtraction means no borrow.
	assign alu_carry = alu_sum[DATA_WIDTH];

	always_comb begin
		wr_req  = 1'b0;
		wr_idx  = dest_q;
		wr_data = b_q;
		unique case (state_q)
			S_DISPATCH: begin
				case (op_q) inside
					rfa_pkg::ACT_IN: begin
						wr_req  = 1'b1;
						wr_data = imm_q;
					end
					rfa_pkg::ACT_MOV, rfa_pkg::ACT_XCHG: wr_req = 1'b1;
					rfa_pkg::ACT_ADD, rfa_pkg::ACT_SUB: begin
						wr_req  = 1'b1;
						wr_data = alu_sum[DATA_WIDTH-1:0];
					end
					rfa_pkg::ACT_AND: begin
						wr_req  = 1'b1;
						wr_data = a_q & b_q;
					end
					rfa_pkg::ACT_OR: begin
						wr_req  = 1'b1;
						wr_data = a_q | b_q;
					end
					rfa_pkg::ACT_XOR: begin
						wr_req  = 1'b1;
						wr_data = a_q ^ b_q;
					end
					default: ;
				endcase
			end
			S_XCHG: begin
				wr_req  = 1'b1;
				wr_idx  = src_q;
				wr_data = a_q;
			end
			S_FIX: begin
				wr_req  = 1'b1;
				wr_data = neg_q ? alu_sum[DATA_WIDTH-1:0] : fix_sel;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (op_q) inside
					rfa_pkg::ACT_XCHG: state_d = S_XCHG;
					rfa_pkg::ACT_MUL:  state_d = S_MUL;
					rfa_pkg::ACT_DIV, rfa_pkg::ACT_MOD:
						state_d = (b_q == '0) ? S_FINISH : S_ABSA;
					default:           state_d = S_FINISH;
				endcase
			end
			S_XCHG: state_d = S_FINISH;
			S_MUL:  if (last_step) state_d = S_FIX;
			S_ABSA: state_d = S_ABSB;
			S_ABSB: state_d = S_DIV;
			S_DIV:  if (last_step) state_d = S_FIX;
			S_FIX:  state_d = S_FINISH;
			S_FINISH: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_wide[IDX_W-1:0]] <= 1'b1;
			end
			if (state_q == S_MUL || state_q == S_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs_mem[wr_wide[IDX_W-1:0]] <= wr_data;
		end
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= stat_q;
			out_value_q  <= (stat_q == rfa_pkg::STAT_OUT) ? rfa_pkg::VALUE_W'($signed(a_q)) : '0;
		end
		unique case (state_q)
			S_IDLE: begin
				op_q   <= instr.action;
				dest_q <= instr.dest_reg;
				src_q  <= instr.first_src;
				imm_q  <= instr.immediate[DATA_WIDTH-1:0];
				stat_q <= rfa_pkg::STAT_NONE;
				neg_q  <= 1'b0;
				if (rd0_wide < WIDE_W'(NUM_REGS) && valid_q[rd0_wide[IDX_W-1:0]]) begin
					a_q <= regs_mem[rd0_wide[IDX_W-1:0]];
				end else begin
					a_q <= '0;
				end
				if (rd1_wide < WIDE_W'(NUM_REGS) && valid_q[rd1_wide[IDX_W-1:0]]) begin
					b_q <= regs_mem[rd1_wide[IDX_W-1:0]];
				end else begin
					b_q <= '0;
				end
			end
			S_DISPATCH: begin
				rem_q <= '0;
				case (op_q) inside
					rfa_pkg::ACT_OUT: stat_q <= rfa_pkg::STAT_OUT;
					rfa_pkg::ACT_DIV: begin
						if (b_q == '0) stat_q <= rfa_pkg::STAT_DIV0;
						neg_q <= a_q[DATA_WIDTH-1] ^ b_q[DATA_WIDTH-1];
					end
					rfa_pkg::ACT_MOD: begin
						if (b_q == '0) stat_q <= rfa_pkg::STAT_DIV0;
						neg_q <= a_q[DATA_WIDTH-1];
					end
					default: ;
				endcase
			end
			S_MUL: begin
				if (a_q[0]) rem_q <= alu_sum[DATA_WIDTH-1:0];
				a_q <= a_q >> 1;
				b_q <= b_q << 1;
			end
			S_ABSA: if (a_q[DATA_WIDTH-1]) a_q <= alu_sum[DATA_WIDTH-1:0];
			S_ABSB: if (b_q[DATA_WIDTH-1]) b_q <= alu_sum[DATA_WIDTH-1:0];
			S_DIV: begin
				// Magnitudes stay at or below half the range, so the partial remainder
				// never needs an extra bit.
				rem_q <= alu_carry ? alu_sum[DATA_WIDTH-1:0] : div_shift;
				a_q   <= {a_q[DATA_WIDTH-2:0], alu_carry};
			end
			default: ;
		endcase
	end

	assign instr.ready      = state_q == S_IDLE;
	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.out_value = out_value_q;

endmodule

>>> src/rfa_checker.sv
module rfa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rfa_pkg::STATUS_W-1:0]      status,
	input logic signed [rfa_pkg::VALUE_W-1:0] out_value
);

	// Only one instruction is worked on at a time.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("instr.ready stayed high after an input transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value))
		else $error("stalled result changed or vanished");

	a_value_only_for_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rfa_pkg::STAT_OUT |-> out_value == '0)
		else $error("nonzero out_value without an OUT status");

	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind register_file_alu_interpreter rfa_checker u_rfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr.valid),
	.in_ready  (instr.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.status    (result.status),
	.out_value (result.out_value)
);

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_REGS = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PER_PHASE = 475;

	localparam logic [rfa_pkg::VALUE_W-1:0] VAL_MAX = {1'b0, {(rfa_pkg::VALUE_W-1){1'b1}}};
	localparam logic [rfa_pkg::VALUE_W-1:0] VAL_MIN = {1'b1, {(rfa_pkg::VALUE_W-1){1'b0}}};
	localparam logic [rfa_pkg::VALUE_W-1:0] VAL_NEG1 = {rfa_pkg::VALUE_W{1'b1}};
	localparam logic [rfa_pkg::VALUE_W-1:0] VAL_ONE = rfa_pkg::VALUE_W'(1);
	localparam logic [rfa_pkg::ACTION_W-1:0] ACT_UNUSED_LO = 4'd12;
	localparam logic [rfa_pkg::ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [rfa_pkg::ACTION_W-1:0] action;
		logic [rfa_pkg::INDEX_W-1:0]  dest;
		logic [rfa_pkg::INDEX_W-1:0]  src1;
		logic [rfa_pkg::INDEX_W-1:0]  src2;
		logic                         three;
		logic [rfa_pkg::VALUE_W-1:0]  imm;
	} instr_t;

	typedef struct packed {
		rfa_pkg::status_t            status;
		logic [rfa_pkg::VALUE_W-1:0] value;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	rfa_in_if  instr_if();
	rfa_out_if result_if();

	register_file_alu_interpreter #(
		.NUM_REGS   (NUM_REGS),
		.DATA_WIDTH (rfa_pkg::VALUE_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_if),
		.result (result_if)
	);

	logic [rfa_pkg::VALUE_W-1:0] shadow_regs [NUM_REGS];
	result_t pending_results [$];
	int error_count = 0;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [rfa_pkg::VALUE_W-1:0] magnitude(
			input logic [rfa_pkg::VALUE_W-1:0] v);
		return v[rfa_pkg::VALUE_W-1] ? -v : v;
	endfunction

	// Executes one instruction on the shadow register file and returns its result.
	function automatic result_t execute_instr(input instr_t ins);
		result_t res;
		logic [rfa_pkg::VALUE_W-1:0] a, b, q, tmp;
		logic neg;
		res.status = rfa_pkg::STAT_NONE;
		res.value = '0;
		a = ins.three ? shadow_regs[ins.src1] : shadow_regs[ins.dest];
		b = ins.three ? shadow_regs[ins.src2] : shadow_regs[ins.src1];
		case (ins.action) inside
			rfa_pkg::ACT_IN:   shadow_regs[ins.dest] = ins.imm;
			rfa_pkg::ACT_MOV:  shadow_regs[ins.dest] = shadow_regs[ins.src1];
			rfa_pkg::ACT_ADD:  shadow_regs[ins.dest] = a + b;
			rfa_pkg::ACT_SUB:  shadow_regs[ins.dest] = a - b;
			rfa_pkg::ACT_MUL:  shadow_regs[ins.dest] = a * b;
			rfa_pkg::ACT_AND:  shadow_regs[ins.dest] = a & b;
			rfa_pkg::ACT_OR:   shadow_regs[ins.dest] = a | b;
			rfa_pkg::ACT_XOR:  shadow_regs[ins.dest] = a ^ b;
			rfa_pkg::ACT_DIV, rfa_pkg::ACT_MOD: begin
				if (b == '0) begin
					res.status = rfa_pkg::STAT_DIV0;
				end else begin
					// Quotient truncates toward zero; the remainder follows the dividend.
					if (ins.action == rfa_pkg::ACT_DIV) begin
						q = magnitude(a) / magnitude(b);
						neg = a[rfa_pkg::VALUE_W-1] ^ b[rfa_pkg::VALUE_W-1];
					end else begin
						q = magnitude(a) % magnitude(b);
						neg = a[rfa_pkg::VALUE_W-1];
					end
					shadow_regs[ins.dest] = neg ? -q : q;
				end
			end
			rfa_pkg::ACT_OUT: begin
				res.status = rfa_pkg::STAT_OUT;
				res.value = shadow_regs[ins.dest];
			end
			rfa_pkg::ACT_XCHG: begin
				tmp = shadow_regs[ins.dest];
				shadow_regs[ins.dest] = shadow_regs[ins.src1];
				shadow_regs[ins.src1] = tmp;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic instr_t make_instr(input logic [rfa_pkg::ACTION_W-1:0] action,
			input int dest, input int src1, input int src2, input logic three,
			input logic [rfa_pkg::VALUE_W-1:0] imm);
		instr_t ins;
		ins.action = action;
		ins.dest = rfa_pkg::INDEX_W'(dest);
		ins.src1 = rfa_pkg::INDEX_W'(src1);
		ins.src2 = rfa_pkg::INDEX_W'(src2);
		ins.three = three;
		ins.imm = imm;
		return ins;
	endfunction

	// Valid is only lowered when an idle cycle follows, so back-to-back items keep it high.
	task automatic send_instr(input instr_t ins);
		while ($urandom_range(99) < src_idle_pct) begin
			instr_if.valid <= 1'b0;
			@(posedge clk);
		end
		instr_if.valid      <= 1'b1;
		instr_if.action     <= ins.action;
		instr_if.dest_reg   <= ins.dest;
		instr_if.first_src  <= ins.src1;
		instr_if.second_src <= ins.src2;
		instr_if.three_form <= ins.three;
		instr_if.immediate  <= ins.imm;
		@(posedge clk);
		while (!instr_if.ready)
			@(posedge clk);
		pending_results.push_back(execute_instr(ins));
	endtask

	task automatic check_result(input logic [rfa_pkg::STATUS_W-1:0] status,
			input logic [rfa_pkg::VALUE_W-1:0] value);
		result_t exp_res;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result transfer, status %0d value %h",
				$realtime, status, value);
			error_count++;
		end else begin
			exp_res = pending_results.pop_front();
			if (status !== exp_res.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$realtime, exp_res.status, status);
				error_count++;
			end
			if (value !== exp_res.value) begin
				$display("%0t: out_value mismatch, expected %h actual %h",
					$realtime, exp_res.value, value);
				error_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready)
			check_result(result_if.status, result_if.out_value);
		result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic test_reset_state();
		send_instr(make_instr(rfa_pkg::ACT_OUT, 0, 0, 0, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_OUT, 3, 0, 0, 1'b1, VAL_NEG1));
	endtask

	task automatic test_extremes();
		send_instr(make_instr(rfa_pkg::ACT_IN, 0, 3, 2, 1'b1, VAL_MAX));
		send_instr(make_instr(rfa_pkg::ACT_IN, 1, 0, 0, 1'b0, VAL_MIN));
		send_instr(make_instr(rfa_pkg::ACT_IN, 2, 0, 0, 1'b0, VAL_NEG1));
		send_instr(make_instr(rfa_pkg::ACT_IN, 3, 0, 0, 1'b0, VAL_ONE));
		// The largest value plus one wraps to the smallest.
		send_instr(make_instr(rfa_pkg::ACT_ADD, 0, 3, 0, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_OUT, 0, 0, 0, 1'b0, '0));
	endtask

	task automatic test_division();
		// The smallest value divided by minus one wraps, and its remainder is zero.
		send_instr(make_instr(rfa_pkg::ACT_DIV, 0, 1, 2, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_OUT, 0, 0, 0, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_MOD, 3, 1, 2, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_OUT, 3, 0, 0, 1'b0, '0));
		// Register 3 now holds zero, so both of these divide by zero.
		send_instr(make_instr(rfa_pkg::ACT_DIV, 0, 3, 0, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_MOD, 1, 2, 3, 1'b1, '0));
	endtask

	task automatic test_each_operation();
		send_instr(make_instr(rfa_pkg::ACT_MUL, 3, 2, 2, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_SUB, 3, 0, 1, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_AND, 1, 3, 2, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_OR, 0, 3, 1, 1'b0, '0));
		send_instr(make_instr(rfa_pkg::ACT_XOR, 2, 0, 3, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_MOV, 1, 2, 0, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_XCHG, 0, 0, 3, 1'b1, '0));
		send_instr(make_instr(rfa_pkg::ACT_XCHG, 1, 3, 0, 1'b0, '0));
		send_instr(make_instr(ACT_UNUSED_HI, 2, 1, 0, 1'b1, VAL_NEG1));
		send_instr(make_instr(rfa_pkg::ACT_OUT, 1, 0, 0, 1'b0, '0));
	endtask

	function automatic instr_t random_instr();
		instr_t ins;
		int pick;
		int small_val;
		pick = $urandom_range(99);
		if (pick < 18)
			ins.action = rfa_pkg::ACT_IN;
		else if (pick < 36)
			ins.action = rfa_pkg::ACT_OUT;
		else if (pick < 40)
			ins.action = rfa_pkg::ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
		else
			ins.action = rfa_pkg::ACTION_W'($urandom_range(rfa_pkg::ACT_XOR,
				rfa_pkg::ACT_IN));
		ins.dest = rfa_pkg::INDEX_W'($urandom_range(3));
		ins.src1 = rfa_pkg::INDEX_W'($urandom_range(3));
		ins.src2 = rfa_pkg::INDEX_W'($urandom_range(3));
		ins.three = 1'($urandom_range(1));
		small_val = $urandom_range(8);
		// Small values give zero and unit divisors often; extremes hit the wrap cases.
		case ($urandom_range(5))
			0: ins.imm = VAL_MAX;
			1: ins.imm = VAL_MIN;
			2: ins.imm = rfa_pkg::VALUE_W'(small_val - 4);
			3: ins.imm = {32'($urandom_range(15)) - 32'd8, 32'($urandom)};
			default: ins.imm = {32'($urandom), 32'($urandom)};
		endcase
		return ins;
	endfunction

	task automatic test_random(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (RANDOM_PER_PHASE)
			send_instr(random_instr());
	endtask

	initial begin
		arst_n              <= 1'b0;
		instr_if.valid      <= 1'b0;
		instr_if.action     <= '0;
		instr_if.dest_reg   <= '0;
		instr_if.first_src  <= '0;
		instr_if.second_src <= '0;
		instr_if.three_form <= 1'b0;
		instr_if.immediate  <= '0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extremes();
		test_division();
		test_each_operation();
		test_random(0, 0);
		test_random(75, 0);
		test_random(0, 75);
		test_random(27, 27);

		@(posedge clk);
		instr_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
